// ===== src/iis_pkg.sv =====
// ----------------------------------------------------------------------------
// iis_pkg: shared types and constants
// Register indexes, field widths and the flag bundle that travels with each
// pixel from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package iis_pkg;

    // configuration register width and reset value
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    // summed-area result width, wraps modulo 2^SUM_W
    localparam int SUM_W = 36;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic first_row;
        logic row_end;
        logic frame_end;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

`default_nettype wire

// ===== src/iis_ram.sv =====
// ----------------------------------------------------------------------------
// iis_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/iis_fifo.sv =====
// ----------------------------------------------------------------------------
// iis_fifo: short register queue
// Small first-in first-out buffer of flip-flops that decouples two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/iis_front.sv =====
// ----------------------------------------------------------------------------
// iis_front: pixel intake and position tracking
// Holds the frame size registers, the column and row counters and the
// running row sum; tags each pixel with its column and row/frame flags.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 26,
    parameter int ITEM_W     = 39
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_index,
    input  wire logic [iis_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                            o_cfg_ready,
    input  wire logic                       i_push,
    input  wire logic [PIXEL_BITS-1:0]      i_pixel,
    input  wire logic                       i_q_full,
    output logic                            o_item_valid,
    output logic      [ITEM_W-1:0]          o_item
);

    localparam int WL_W = ($clog2(MAX_WIDTH + 1) > iis_pkg::CFG_W) ?
                          $clog2(MAX_WIDTH + 1) : iis_pkg::CFG_W;
    localparam int HL_W = ($clog2(MAX_HEIGHT + 1) > iis_pkg::CFG_W) ?
                          $clog2(MAX_HEIGHT + 1) : iis_pkg::CFG_W;
    localparam int RP_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [iis_pkg::CFG_W-1:0] r_width, r_height;
    logic [COL_W-1:0]          r_col;
    logic [RP_W-1:0]           r_row;
    logic [ROW_W-1:0]          r_row_sum;

    logic [WL_W-1:0]  w_width_ext, w_eff_width;
    logic [HL_W-1:0]  w_height_ext, w_eff_height;
    logic [ROW_W-1:0] w_sum;
    logic             w_accept;
    iis_pkg::t_flags  w_flags;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_push && !i_q_full;

    // zero counts as one, oversize saturates
    always_comb begin
        w_width_ext  = WL_W'(r_width);
        w_height_ext = HL_W'(r_height);
        if (w_width_ext == '0) begin
            w_eff_width = WL_W'(1);
        end else if (w_width_ext > WL_W'(MAX_WIDTH)) begin
            w_eff_width = WL_W'(MAX_WIDTH);
        end else begin
            w_eff_width = w_width_ext;
        end
        if (w_height_ext == '0) begin
            w_eff_height = HL_W'(1);
        end else if (w_height_ext > HL_W'(MAX_HEIGHT)) begin
            w_eff_height = HL_W'(MAX_HEIGHT);
        end else begin
            w_eff_height = w_height_ext;
        end
    end

    always_comb begin
        w_sum             = r_row_sum + ROW_W'(i_pixel);
        w_flags.first_row = (r_row == '0);
        w_flags.row_end   = ((WL_W'(r_col) + WL_W'(1)) >= w_eff_width);
        w_flags.frame_end = w_flags.row_end &&
                            ((HL_W'(r_row) + HL_W'(1)) >= w_eff_height);
    end

    assign o_item_valid = w_accept;
    assign o_item       = {r_col, w_sum, w_flags};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= iis_pkg::DIM_RESET;
            r_height  <= iis_pkg::DIM_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (iis_pkg::t_cfg_index'(i_cfg_index))
                    iis_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    iis_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_flags.row_end) begin
                    r_col     <= '0;
                    r_row_sum <= '0;
                    r_row     <= w_flags.frame_end ? '0 : r_row + RP_W'(1);
                end else begin
                    r_col     <= r_col + COL_W'(1);
                    r_row_sum <= w_sum;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/iis_back.sv =====
// ----------------------------------------------------------------------------
// iis_back: line store update
// Reads the previous row's integral value for each column, adds the row
// sum and writes the result back into the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module iis_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10,
    parameter int ROW_W     = 26,
    parameter int ITEM_W    = 39,
    parameter int RES_W     = 38
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ITEM_W-1:0] i_item,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_valid,
    output logic      [RES_W-1:0]  o_res
);

    localparam int SUM_W = iis_pkg::SUM_W;

    logic [COL_W-1:0]    w_in_col;
    logic [ROW_W-1:0]    w_in_sum;
    iis_pkg::t_flags     w_in_flags;

    logic                r_s1_valid;
    logic [COL_W-1:0]    r_s1_col;
    logic [ROW_W-1:0]    r_s1_sum;
    iis_pkg::t_flags     r_s1_flags;

    // last line store write, forwarded to cover the read-during-write case
    logic                r_lw_valid;
    logic [COL_W-1:0]    r_lw_col;
    logic [SUM_W-1:0]    r_lw_data;

    logic [SUM_W-1:0]    w_rdata, w_above, w_area;
    logic                w_fire, w_load;

    assign {w_in_col, w_in_sum, w_in_flags} = i_item;

    assign w_fire  = r_s1_valid && !i_res_full;
    assign w_load  = !r_s1_valid || w_fire;
    assign o_q_pop = w_load && !i_q_empty;

    iis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_s1_col),
        .i_wdata (w_area),
        .i_re    (o_q_pop),
        .i_raddr (w_in_col),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_s1_flags.first_row) begin
            w_above = '0;
        end else if (r_lw_valid && (r_lw_col == r_s1_col)) begin
            w_above = r_lw_data;
        end else begin
            w_above = w_rdata;
        end
        w_area = w_above + SUM_W'(r_s1_sum);
    end

    assign o_res_valid = w_fire;
    assign o_res       = {w_area, r_s1_flags.row_end, r_s1_flags.frame_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_s1_valid <= !i_q_empty;
            end
            if (w_fire) begin
                r_lw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_col   <= w_in_col;
            r_s1_sum   <= w_in_sum;
            r_s1_flags <= w_in_flags;
        end
        if (w_fire) begin
            r_lw_col  <= r_s1_col;
            r_lw_data <= w_area;
        end
    end

endmodule

`default_nettype wire

// ===== src/integral_image_stream.sv =====
// ----------------------------------------------------------------------------
// integral_image_stream: streaming summed-area table
// Pixels pass item queue, line store stage and result queue; one pixel per
// cycle unless stalled, set by one line store read and write per column.
// Synchronous active-low reset clears counters, row sum and queues and sets
// frame size to 1024 x 1024; the line store is not cleared, the first row
// of each frame never reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module integral_image_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_index,
    input  wire logic [iis_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                            o_cfg_ready,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [PIXEL_BITS-1:0]      i_pixel,
    output logic                            empty,
    input  wire logic                       pop,
    output logic      [iis_pkg::SUM_W-1:0]  o_area_sum,
    output logic                            o_row_end,
    output logic                            o_frame_end
);

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_RAW = PIXEL_BITS + $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = (ROW_RAW > iis_pkg::SUM_W) ? iis_pkg::SUM_W : ROW_RAW;
    localparam int ITEM_W  = COL_W + ROW_W + iis_pkg::FLAGS_W;
    localparam int RES_W   = iis_pkg::SUM_W + 2;

    logic              w_item_valid, w_q_full, w_q_empty, w_q_pop;
    logic [ITEM_W-1:0] w_item_in, w_item_out;
    logic              w_res_valid, w_res_full;
    logic [RES_W-1:0]  w_res_in, w_res_out;

    iis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_push       (push),
        .i_pixel      (i_pixel),
        .i_q_full     (w_q_full),
        .o_item_valid (w_item_valid),
        .o_item       (w_item_in)
    );

    assign full = w_q_full;

    // queue between front and back
    iis_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_item_valid),
        .i_data  (w_item_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_item_out),
        .o_empty (w_q_empty)
    );

    iis_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W),
        .ITEM_W    (ITEM_W),
        .RES_W     (RES_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item_out),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_res_full  (w_res_full),
        .o_res_valid (w_res_valid),
        .o_res       (w_res_in)
    );

    iis_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign {o_area_sum, o_row_end, o_frame_end} = w_res_out;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for integral_image_stream
// Streams Q8.8 pixels through the queue-style ports with random gaps on both
// sides, predicts every summed-area result with a behavioral integral image
// and compares each popped result in order. Frame size is changed only while
// the block is drained, including mid-frame narrowing and height changes.
// ----------------------------------------------------------------------------

module tb;

    localparam int CFG_W       = iis_pkg::CFG_W;
    localparam int SUM_W       = iis_pkg::SUM_W;
    localparam int PIX_W       = 16;
    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int RANDOM_PIX  = 1750;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic [SUM_W-1:0] area;
        logic             row_end;
        logic             frame_end;
    } t_area_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             push        = 1'b0;
    logic [PIX_W-1:0] i_pixel     = '0;
    logic             pop         = 1'b0;
    wire              o_cfg_ready;
    wire              full;
    wire              empty;
    wire  [SUM_W-1:0] o_area_sum;
    wire              o_row_end;
    wire              o_frame_end;

    integral_image_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_area_sum  (o_area_sum),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always #5 i_clk = ~i_clk;

    // integral image state, mirrors the block
    logic [CFG_W-1:0] width_reg  = iis_pkg::DIM_RESET;
    logic [CFG_W-1:0] height_reg = iis_pkg::DIM_RESET;
    logic [SUM_W-1:0] row_sum    = '0;
    logic [SUM_W-1:0] line_sums    [MAX_W];
    bit               line_written [MAX_W];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    logic [PIX_W-1:0] pixel_q[$];
    t_area_result     area_expect_q[$];

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned pixels_in = 0;
    int unsigned results_out = 0;
    int unsigned frames_done = 0;
    int unsigned cfg_writes = 0;
    int unsigned full_stalls = 0;

    function automatic int unsigned dim_limit(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned gap_len(bit enable);
        int unsigned r;
        if (!enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'($urandom_range(MAX_W + 1, (1 << CFG_W) - 1));
            2:       return CFG_W'(MAX_W);
            3:       return CFG_W'(1);
            4:       return CFG_W'($urandom_range(100, MAX_W - 1));
            default: return CFG_W'($urandom_range(2, 20));
        endcase
    endfunction

    task automatic accumulate_pixel(logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        logic [SUM_W-1:0] above;
        t_area_result     r;
        w = dim_limit(width_reg, MAX_W);
        h = dim_limit(height_reg, MAX_H);
        row_sum = row_sum + pix;
        above = (row_pos != 0) ? line_sums[col_pos] : '0;
        r.area = above + row_sum;
        line_sums[col_pos] = r.area;
        line_written[col_pos] = 1'b1;
        r.row_end = (col_pos + 1 >= w);
        r.frame_end = r.row_end && (row_pos + 1 >= h);
        if (r.row_end) begin
            row_sum = '0;
            col_pos = 0;
            row_pos = r.frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        if (r.frame_end) frames_done++;
        area_expect_q.push_back(r);
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // returns at a falling edge with nothing in flight
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || push || area_expect_q.size() != 0);
    endtask

    task automatic write_reg(iis_pkg::t_cfg_index idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == iis_pkg::CFG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // pixel sender
    always @(posedge i_clk) begin
        int unsigned tx_gap;
        if (!i_rst_n) begin
            push <= 1'b0;
            tx_gap = 0;
        end else begin
            if (push && !full) begin
                accumulate_pixel(i_pixel);
                pixels_in++;
            end
            if (push && full) begin
                full_stalls++;
            end else if (tx_gap != 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                i_pixel <= pixel_q.pop_front();
                push <= 1'b1;
                tx_gap = gap_len(tx_idle);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // long receiver hold-off to back the block up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result receiver and checker
    always @(posedge i_clk) begin
        t_area_result exp_r;
        int unsigned  rx_gap;
        if (!i_rst_n) begin
            pop <= 1'b0;
            rx_gap = 0;
        end else begin
            if (pop && !empty) begin
                results_out++;
                if (area_expect_q.size() == 0) begin
                    flag_mismatch($sformatf(
                        "result with nothing expected, area %0h row_end %0b frame_end %0b",
                        o_area_sum, o_row_end, o_frame_end));
                end else begin
                    exp_r = area_expect_q.pop_front();
                    if (o_area_sum !== exp_r.area || o_row_end !== exp_r.row_end ||
                        o_frame_end !== exp_r.frame_end)
                        flag_mismatch($sformatf(
                            "result %0d exp/got area %0h/%0h row_end %0b/%0b frame_end %0b/%0b",
                            results_out, exp_r.area, o_area_sum, exp_r.row_end, o_row_end,
                            exp_r.frame_end, o_frame_end));
                end
                rx_gap = gap_len(rx_idle);
            end
            if (hold_left != 0) begin
                pop <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned      w;
        int unsigned      h;
        int unsigned      n;
        int unsigned      cur_left;
        int unsigned      rows_after;
        int unsigned      random_pixels;
        int unsigned      phase;
        int unsigned      sel;
        logic [CFG_W-1:0] new_w;
        logic [PIX_W-1:0] px;
        bit               ok;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // start of a full-size frame at reset sizes
        pixel_q.push_back(16'hFFFF);
        pixel_q.push_back(16'h0000);
        wait_drained();
        // narrow the width mid-row, then finish a two-row frame
        write_reg(iis_pkg::CFG_FRAME_WIDTH, 11'd3);
        write_reg(iis_pkg::CFG_FRAME_HEIGHT, 11'd2);
        pixel_q.push_back(16'hFFFF);
        pixel_q.push_back(16'h0001);
        pixel_q.push_back(16'h8000);
        pixel_q.push_back(16'hFFFF);
        wait_drained();
        // zero sizes act as one: every pixel is a frame
        write_reg(iis_pkg::CFG_FRAME_WIDTH, 11'd0);
        write_reg(iis_pkg::CFG_FRAME_HEIGHT, 11'd0);
        pixel_q.push_back(16'h00FF);
        pixel_q.push_back(16'hFF00);
        wait_drained();
        // oversized height saturates
        write_reg(iis_pkg::CFG_FRAME_HEIGHT, 11'h7FF);
        write_reg(iis_pkg::CFG_FRAME_WIDTH, 11'd2);
        pixel_q.push_back(16'h0001);
        pixel_q.push_back(16'h0002);
        pixel_q.push_back(16'h0003);
        wait_drained();
        // shrink height mid-frame: the current row closes the frame
        write_reg(iis_pkg::CFG_FRAME_HEIGHT, 11'd1);
        pixel_q.push_back(16'hFFFF);
        wait_drained();
        // oversized width saturates, then narrow mid-row
        write_reg(iis_pkg::CFG_FRAME_WIDTH, 11'h7FF);
        write_reg(iis_pkg::CFG_FRAME_HEIGHT, 11'd2);
        repeat (4) pixel_q.push_back(16'hFFFF);
        wait_drained();
        write_reg(iis_pkg::CFG_FRAME_WIDTH, 11'd4);
        repeat (5) pixel_q.push_back(16'hFFFF);

        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIX) begin
            wait_drained();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 2);
                if (sel != 0) write_reg(iis_pkg::CFG_FRAME_HEIGHT, pick_dim());
                if (sel != 1) begin
                    new_w = pick_dim();
                    // widening in a row that reads the line store needs those columns filled
                    ok = 1'b1;
                    if (row_pos != 0)
                        for (int c = col_pos; c < dim_limit(new_w, MAX_W); c++)
                            if (!line_written[c]) ok = 1'b0;
                    if (ok) write_reg(iis_pkg::CFG_FRAME_WIDTH, new_w);
                end
            end
            w = dim_limit(width_reg, MAX_W);
            h = dim_limit(height_reg, MAX_H);
            cur_left = (col_pos + 1 >= w) ? 1 : w - col_pos;
            rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
            n = cur_left + rows_after * w;
            if (n > 400 || $urandom_range(0, 9) < 3) n = $urandom_range(1, 120);
            if (phase == 2) begin
                tx_idle = 1'b0;
                hold_req = 1'b1;
                n = 200;
            end
            if (n > RANDOM_PIX - random_pixels) n = RANDOM_PIX - random_pixels;
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
                endcase
                pixel_q.push_back(px);
            end
            random_pixels += n;
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (area_expect_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", area_expect_q.size()));

        $display("covered %0d pixels, %0d results, %0d frames, %0d register writes",
                 pixels_in, results_out, frames_done, cfg_writes);
        $display("input held off by a full block on %0d cycles, %0d mismatches",
                 full_stalls, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting for the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/iis_pkg.sv
src/iis_ram.sv
src/iis_fifo.sv
src/iis_front.sv
src/iis_back.sv
src/integral_image_stream.sv
sim/tb.sv
